### hdl/ledw_pkg.sv
// shared constants and types for the two-wire LED frame writer
// no dependencies; used by the top level
`default_nettype none

package ledw_pkg;

    localparam int unsigned NUM_DIGITS = 4;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_CTRL  = 2'd1;
    localparam logic [1:0] CMD_DIGIT = 2'd2;

    localparam logic [7:0] FIRST_CTRL  = 8'h48;
    localparam logic [7:0] FIRST_DIGIT = 8'h68;

    localparam logic [5:0] PH_IDLE   = 6'd0;
    localparam logic [5:0] PH_START0 = 6'd1;
    localparam logic [5:0] PH_START1 = 6'd2;
    localparam logic [5:0] PH_START2 = 6'd3;
    localparam logic [5:0] PH_BYTE0  = 6'd4;
    localparam logic [5:0] PH_BYTE1  = 6'd31;
    localparam logic [5:0] PH_STOP   = 6'd58;
    localparam logic [5:0] PH_LAST   = 6'd59;

    localparam logic [1:0] SUB_LOW  = 2'd0;
    localparam logic [1:0] SUB_MID  = 2'd1;
    localparam logic [1:0] SUB_HIGH = 2'd2;

    localparam logic [1:0] ADDR_PHASE_TICKS = 2'd0;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

    typedef struct packed {
        logic scl;
        logic sda_out;
        logic sda_sampling;
        logic busy_res;
        logic frame_done;
        logic nack_seen;
        logic rejected;
    } t_res;

endpackage

`default_nettype wire

### hdl/ledw_ifs.sv
// valid/ready channel interfaces for tick requests and per-tick results
// depends on nothing; used by the top level
`default_nettype none

interface ledw_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [1:0] digit;
    logic [7:0] data_byte;
    logic       sda_in;

    modport source (output valid, cmd, digit, data_byte, sda_in, input ready);
    modport sink   (input valid, cmd, digit, data_byte, sda_in, output ready);
endinterface

interface ledw_res_if;
    logic valid;
    logic ready;
    logic scl;
    logic sda_out;
    logic sda_sampling;
    logic busy_res;
    logic frame_done;
    logic nack_seen;
    logic rejected;

    modport source (output valid, scl, sda_out, sda_sampling, busy_res, frame_done,
                    nack_seen, rejected, input ready);
    modport sink   (input valid, scl, sda_out, sda_sampling, busy_res, frame_done,
                    nack_seen, rejected, output ready);
endinterface

`default_nettype wire

### hdl/led_driver_two_wire_frame_writer_top.sv
// two-wire frame writer for an LED display controller, one bus tick per beat
// depends on ledw_pkg and the channel interfaces in ledw_ifs.sv
//
// channel   dir   handshake          beat
// i_tick    in    valid/ready        cmd, digit, data_byte, sda_in
// o_res     out   valid/ready        scl, sda_out, sda_sampling, busy_res,
//                                    frame_done, nack_seen, rejected
// apb       in    psel/penable       phase_ticks at byte address 0
//
// one tick beat per clock cycle unless the result side stalls; one result beat
// per tick, registered. the result register decouples the sides; a tick is
// taken whenever the result register is empty or being drained
// synchronous active-low reset: idle, both lines high, phase_ticks 10
`default_nettype none

module led_driver_two_wire_frame_writer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ledw_tick_if.sink   i_tick,
    ledw_res_if.source  o_res,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ledw_pkg::*;

    logic [15:0] r_phase_ticks;
    logic [5:0]  r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_second, n_second;
    logic [3:0]  r_bit, n_bit;
    logic [1:0]  r_sub, n_sub;
    logic        r_nack, n_nack;
    logic [1:0]  r_line, n_line;
    logic        r_out_valid;
    t_res        r_res, n_res;

    logic        w_accept;
    logic        w_req;
    logic [1:0]  w_dig;
    logic [15:0] w_lim;
    logic        w_scl;
    logic        w_sda;
    logic        w_in_byte;
    logic        w_ack;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_PHASE_TICKS) ? {16'd0, r_phase_ticks} : 32'd0;
    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign w_accept = i_tick.valid && i_tick.ready;
    assign w_req    = (i_tick.cmd == CMD_CTRL) || (i_tick.cmd == CMD_DIGIT);
    assign w_dig    = ({1'b0, i_tick.digit} >= 3'(NUM_DIGITS)) ?
                      2'(NUM_DIGITS - 1) : i_tick.digit;
    assign w_lim    = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_shift  = r_shift;
        n_second = r_second;
        n_bit    = r_bit;
        n_sub    = r_sub;
        n_nack   = r_nack;
        n_line   = r_line;
        n_res    = '0;
        w_scl    = 1'b1;
        w_sda    = 1'b1;
        w_in_byte = 1'b0;
        w_ack    = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (w_req) begin
                n_shift  = (i_tick.cmd == CMD_CTRL) ? FIRST_CTRL :
                           FIRST_DIGIT + {5'd0, w_dig, 1'b0};
                n_second = i_tick.data_byte;
                n_bit    = 4'd0;
                n_nack   = 1'b0;
                n_phase  = PH_START0;
                n_tick   = 16'd0;
                n_sub    = SUB_LOW;
            end
        end else if (w_req) begin
            n_res.rejected = 1'b1;
        end

        // phase kind of this tick, before any advance
        w_in_byte = (n_phase >= PH_BYTE0) && (n_phase < PH_STOP);
        w_ack     = n_bit[3];

        if (n_phase == PH_IDLE) begin
            w_scl = n_line[1];
            w_sda = n_line[0];
        end else begin
            n_res.busy_res = 1'b1;
            if (n_phase == PH_START0) begin
                w_scl = 1'b1; w_sda = 1'b1;
            end else if (n_phase == PH_START1 || n_phase == PH_LAST) begin
                w_scl = 1'b1; w_sda = 1'b0;
            end else if (n_phase == PH_START2 || n_phase == PH_STOP) begin
                w_scl = 1'b0; w_sda = 1'b0;
            end else if (w_ack) begin
                w_scl = (n_sub == SUB_MID);
                w_sda = 1'b1;
                n_res.sda_sampling = (n_sub != SUB_LOW);
            end else if (n_sub == SUB_LOW) begin
                w_scl = 1'b0; w_sda = n_line[0];
            end else begin
                w_scl = (n_sub == SUB_HIGH); w_sda = n_shift[0];
            end
            n_line = {w_scl, w_sda};
            n_tick = n_tick + 16'd1;
            if (n_tick >= w_lim) begin
                n_tick = 16'd0;
                if (w_in_byte && !w_ack && n_sub == SUB_HIGH) begin
                    n_shift = {1'b0, n_shift[7:1]};
                    n_bit   = n_bit + 4'd1;
                end else if (w_in_byte && w_ack && n_sub == SUB_MID) begin
                    if (i_tick.sda_in) begin
                        n_nack = 1'b1;
                    end
                end else if (w_in_byte && w_ack && n_sub == SUB_HIGH &&
                             n_phase < PH_BYTE1) begin
                    n_shift = n_second;
                    n_bit   = 4'd0;
                end
                if (w_in_byte) begin
                    n_sub = (n_sub == SUB_HIGH) ? SUB_LOW : n_sub + 2'd1;
                end
                if (n_phase == PH_LAST) begin
                    n_phase = PH_IDLE;
                    n_res.frame_done = 1'b1;
                    n_line = 2'b11;
                end else begin
                    n_phase = n_phase + 6'd1;
                end
            end
        end
        n_res.scl       = w_scl;
        n_res.sda_out   = w_sda;
        n_res.nack_seen = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_phase       <= PH_IDLE;
            r_tick        <= 16'd0;
            r_shift       <= 8'd0;
            r_second      <= 8'd0;
            r_bit         <= 4'd0;
            r_sub         <= SUB_LOW;
            r_nack        <= 1'b0;
            r_line        <= 2'b11;
            r_out_valid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                r_phase_ticks <= pwdata[15:0];
            end
            if (w_accept) begin
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_shift  <= n_shift;
                r_second <= n_second;
                r_bit    <= n_bit;
                r_sub    <= n_sub;
                r_nack   <= n_nack;
                r_line   <= n_line;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.scl          = r_res.scl;
    assign o_res.sda_out      = r_res.sda_out;
    assign o_res.sda_sampling = r_res.sda_sampling;
    assign o_res.busy_res     = r_res.busy_res;
    assign o_res.frame_done   = r_res.frame_done;
    assign o_res.nack_seen    = r_res.nack_seen;
    assign o_res.rejected     = r_res.rejected;

`ifndef SYNTHESIS
    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_tick == 16'd0)
        else $error("tick counter not clear while idle");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit count beyond one byte");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.frame_done |-> r_res.busy_res && r_phase == PH_IDLE)
        else $error("frame done outside a frame");
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.sda_sampling || r_res.rejected) |-> r_res.busy_res)
        else $error("sampling or reject while idle");
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_line == 2'b11)
        else $error("lines not released while idle");
`endif

endmodule

`default_nettype wire
